// File: hdl/button_click_double_click_detector_assert.svh
// Assertion macros used by the checker of the button click detector.
`ifndef BUTTON_CLICK_DOUBLE_CLICK_DETECTOR_ASSERT_SVH
`define BUTTON_CLICK_DOUBLE_CLICK_DETECTOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BCDD_ASSERT_NOW(label, ant, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BCDD_ASSERT_NEXT(label, ant, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/bcdd_pkg.sv
// Types, constants and the per-button click logic of the button click detector.
package bcdd_pkg;

    // Field widths
    localparam int LEVELS_W    = 3;
    localparam int TIME_W      = 32;
    localparam int POS_W       = 16;
    localparam int MOVE_W      = POS_W + 1;
    localparam int WINDOW_W    = 16;
    localparam int COUNT_W     = 2;
    localparam int S_TDATA_W   = 72;
    localparam int M_TDATA_W   = 48;
    localparam int NUM_EV_OUT  = 3;

    // Defaults
    localparam int BCDD_NUM_BUTTONS = 3;
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd500;

    // Event codes reported per button
    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_DOWN   = 3'd1,
        EV_UP     = 3'd2,
        EV_HELD   = 3'd3,
        EV_DOUBLE = 3'd4
    } ev_t;

    // Outcome of one button for one poll tick
    typedef struct packed {
        ev_t                ev;
        logic [COUNT_W-1:0] count;
        logic               start_we;
    } btn_upd_t;

    // Edge detection and double-click tracking for one button.
    function automatic btn_upd_t button_step(
        input logic                prev,
        input logic                lvl,
        input logic [COUNT_W-1:0]  cnt,
        input logic [TIME_W-1:0]   start,
        input logic [TIME_W-1:0]   now,
        input logic [WINDOW_W-1:0] win
    );
        logic [TIME_W-1:0]  elapsed;
        logic [TIME_W-1:0]  win_ext;
        logic [COUNT_W-1:0] c;
        btn_upd_t           r;
        elapsed    = now - start;
        win_ext    = {{(TIME_W-WINDOW_W){1'b0}}, win};
        c          = cnt;
        r.start_we = 1'b0;
        case ({prev, lvl})
            2'b01:   r.ev = EV_DOWN;
            2'b10:   r.ev = EV_UP;
            2'b11:   r.ev = EV_HELD;
            default: r.ev = EV_NONE;
        endcase
        if (r.ev == EV_DOWN) begin
            // A stale first click no longer pairs with this press.
            if (c == 2'd1 && elapsed >= win_ext) begin
                c = '0;
            end
            c          = c + 2'd1;
            r.start_we = (c == 2'd1);
        end else if (r.ev == EV_UP) begin
            if (c == 2'd1) begin
                if (elapsed >= win_ext) begin
                    c = '0;
                end
            end else if (c == 2'd2) begin
                if (elapsed <= win_ext) begin
                    r.ev = EV_DOUBLE;
                end
                c = '0;
            end
        end
        r.count = c;
        return r;
    endfunction

endpackage

// File: hdl/button_click_double_click_detector.sv
// Top level of the mouse button edge and double-click detector.
// One poll request is taken per clock cycle unless the result side stalls. Its result
// request is presented once it has passed from the input register into the result register:
// the request is held in an input register, and the per-button edge compare, the 32-bit
// elapsed-time subtract and compare against the window, and the cursor subtractions run in
// one combinational pass into the result register, updating the kept button state in the
// same cycle. Both sides may stall independently; the output and input registers keep the
// stream moving at full rate. The user must write the window register through cfg_wr_en
// and cfg_wr_data only while no request is in flight; the block does not enforce this.
module button_click_double_click_detector
    import bcdd_pkg::*;
#(
    parameter int NUM_BUTTONS = BCDD_NUM_BUTTONS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration: double-click window in milliseconds
    input  logic                  cfg_wr_en,
    input  logic [WINDOW_W-1:0]   cfg_wr_data,
    // Poll requests
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // s_tdata: button_levels[2:0], now_ms[34:3], cursor_x[50:35], cursor_y[66:51], zeros
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // Result requests
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // m_tdata: left_event[2:0], right_event[5:3], middle_event[8:6], move_x[25:9],
    //          move_y[42:26], zeros
    output logic [M_TDATA_W-1:0]  m_tdata
);

    // Input register
    logic                in_valid_reg;
    logic [LEVELS_W-1:0] in_levels_reg;
    logic [TIME_W-1:0]   in_now_reg;
    logic [POS_W-1:0]    in_x_reg;
    logic [POS_W-1:0]    in_y_reg;

    // Result register
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic [M_TDATA_W-1:0] out_data_next;

    // Kept state
    logic [WINDOW_W-1:0]  window_reg;
    logic [NUM_BUTTONS-1:0] prev_level_reg;
    logic [NUM_BUTTONS-1:0] prev_level_next;
    logic [COUNT_W-1:0]   click_count_reg  [NUM_BUTTONS];
    logic [TIME_W-1:0]    click_start_reg  [NUM_BUTTONS];
    logic [POS_W-1:0]     prev_x_reg;
    logic [POS_W-1:0]     prev_y_reg;

    btn_upd_t             upd [NUM_BUTTONS];
    ev_t                  ev_out [NUM_EV_OUT];
    logic [MOVE_W-1:0]    move_x;
    logic [MOVE_W-1:0]    move_y;
    logic                 advance;

    // Handshake: move the held request forward when the result slot is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Input register capture
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            in_levels_reg <= s_tdata[2:0];
            in_now_reg    <= s_tdata[34:3];
            in_x_reg      <= s_tdata[50:35];
            in_y_reg      <= s_tdata[66:51];
        end
    end

    // Per-button click logic; buttons past the third always see a released level
    for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_btn
        logic lvl;
        if (i < LEVELS_W) begin : g_lvl
            assign lvl = in_levels_reg[i];
        end else begin : g_nolvl
            assign lvl = 1'b0;
        end

        assign upd[i] = button_step(prev_level_reg[i], lvl, click_count_reg[i],
                                    click_start_reg[i], in_now_reg, window_reg);
        assign prev_level_next[i] = lvl;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                click_count_reg[i] <= '0;
            end else if (advance) begin
                click_count_reg[i] <= upd[i].count;
            end
            if (advance && upd[i].start_we) begin
                click_start_reg[i] <= in_now_reg;
            end
        end
    end

    // Event fields of buttons that are not built read as none
    for (genvar k = 0; k < NUM_EV_OUT; k++) begin : g_ev
        if (k < NUM_BUTTONS) begin : g_on
            assign ev_out[k] = upd[k].ev;
        end else begin : g_off
            assign ev_out[k] = EV_NONE;
        end
    end

    // Cursor movement since the previous request
    assign move_x = {in_x_reg[POS_W-1], in_x_reg} - {prev_x_reg[POS_W-1], prev_x_reg};
    assign move_y = {in_y_reg[POS_W-1], in_y_reg} - {prev_y_reg[POS_W-1], prev_y_reg};

    always_comb begin
        out_data_next = {{(M_TDATA_W - 3*3 - 2*MOVE_W){1'b0}}, move_y, move_x,
                         ev_out[2], ev_out[1], ev_out[0]};
    end

    // Result register and kept state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            prev_level_reg <= '0;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            window_reg     <= WINDOW_RESET;
        end else begin
            if (advance) begin
                out_valid_reg  <= 1'b1;
                prev_level_reg <= prev_level_next;
                prev_x_reg     <= in_x_reg;
                prev_y_reg     <= in_y_reg;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                window_reg <= cfg_wr_data;
            end
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

// File: hdl/bcdd_checker.sv
// Port-level checker for the button click detector and its bind.
`include "button_click_double_click_detector_assert.svh"

module bcdd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);

    logic out_stall;
    logic ev_ok;

    assign out_stall = m_tvalid && !m_tready;
    assign ev_ok     = (m_tdata[2:0] <= 3'd4) && (m_tdata[5:3] <= 3'd4) &&
                       (m_tdata[8:6] <= 3'd4);

    // A stalled result request holds its payload.
    `BCDD_ASSERT_NEXT(a_out_hold, out_stall, m_tvalid && $stable(m_tdata), "result not held")

    // Every event field carries a defined code.
    `BCDD_ASSERT_NOW(a_ev_range, m_tvalid, ev_ok, "event code out of range")

    // Padding bits above the move fields stay zero.
    `BCDD_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[47:43] == 5'd0, "padding bits not zero")

    // A draining output never blocks the input side.
    `BCDD_ASSERT_NOW(a_flow, m_tready, s_tready, "input stalled while output drains")

endmodule

bind button_click_double_click_detector bcdd_checker u_bcdd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: tb/tb.sv
// Self-checking stream testbench for the mouse button edge and double-click detector.
`timescale 1ns / 100ps

module tb;
    import bcdd_pkg::*;

    // One expected result request, packed the same way as the detector's m_tdata.
    typedef struct packed {
        logic [MOVE_W-1:0] move_y;
        logic [MOVE_W-1:0] move_x;
        ev_t               middle;
        ev_t               right;
        ev_t               left;
    } report_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [WINDOW_W-1:0]  cfg_wr_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    // Predictor state: kept levels, click counters, first press times, cursor, window.
    logic                prev_level [NUM_EV_OUT];
    logic [COUNT_W-1:0]  clicks [NUM_EV_OUT];
    logic [TIME_W-1:0]   press_ms [NUM_EV_OUT];
    logic [POS_W-1:0]    last_x;
    logic [POS_W-1:0]    last_y;
    logic [WINDOW_W-1:0] click_window;

    // Stimulus state: the poll clock, the button levels and the cursor being generated.
    logic [TIME_W-1:0]   poll_ms;
    logic [LEVELS_W-1:0] gen_levels;
    logic [POS_W-1:0]    gen_x;
    logic [POS_W-1:0]    gen_y;

    report_t pending_reports[$];
    int      mismatch_count;
    int      send_idle_pct;
    int      recv_idle_pct;
    int      hold_left;

    button_click_double_click_detector uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Run limit, far above the slowest correct run.
    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

    // Edge and double-click tracking of one button; updates the predictor state.
    function automatic ev_t track_button(int b, logic lvl, logic [TIME_W-1:0] now);
        ev_t               ev;
        logic [TIME_W-1:0] elapsed;
        logic [TIME_W-1:0] win;
        win     = {{(TIME_W-WINDOW_W){1'b0}}, click_window};
        elapsed = now - press_ms[b];
        if (!prev_level[b] && lvl) begin
            ev = EV_DOWN;
        end else if (prev_level[b] && !lvl) begin
            ev = EV_UP;
        end else if (prev_level[b] && lvl) begin
            ev = EV_HELD;
        end else begin
            ev = EV_NONE;
        end
        prev_level[b] = lvl;
        if (ev == EV_DOWN) begin
            // A first click that has run out of time no longer pairs with this press.
            if (clicks[b] == 2'd1 && elapsed >= win) begin
                clicks[b] = 2'd0;
            end
            clicks[b] = clicks[b] + 2'd1;
            if (clicks[b] == 2'd1) begin
                press_ms[b] = now;
            end
        end else if (ev == EV_UP) begin
            if (clicks[b] == 2'd1) begin
                if (elapsed >= win) begin
                    clicks[b] = 2'd0;
                end
            end else if (clicks[b] == 2'd2) begin
                if (elapsed <= win) begin
                    ev = EV_DOUBLE;
                end
                clicks[b] = 2'd0;
            end
        end
        return ev;
    endfunction

    // Expected result of one poll request.
    function automatic report_t predict_report(logic [LEVELS_W-1:0] levels,
                                               logic [TIME_W-1:0] now,
                                               logic [POS_W-1:0] x, logic [POS_W-1:0] y);
        report_t r;
        r.left   = track_button(0, levels[0], now);
        r.right  = track_button(1, levels[1], now);
        r.middle = track_button(2, levels[2], now);
        r.move_x = {x[POS_W-1], x} - {last_x[POS_W-1], last_x};
        r.move_y = {y[POS_W-1], y} - {last_y[POS_W-1], last_y};
        last_x   = x;
        last_y   = y;
        return r;
    endfunction

    task automatic compare_field(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    // Compare one result request with the oldest expectation.
    task automatic check_report(logic [M_TDATA_W-1:0] data);
        report_t want;
        if (pending_reports.size() == 0) begin
            $display("%0t: unexpected result request, expected none, actual 0x%0h",
                     $time, data);
            mismatch_count++;
        end else begin
            want = pending_reports.pop_front();
            compare_field("left_event", want.left, data[2:0]);
            compare_field("right_event", want.right, data[5:3]);
            compare_field("middle_event", want.middle, data[8:6]);
            compare_field("move_x", want.move_x, data[25:9]);
            compare_field("move_y", want.move_y, data[42:26]);
        end
    endtask

    // Receiver: checks every accepted result and stalls at random or for a hold-off.
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                check_report(m_tdata);
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Offer one poll request and record its expected result once it is accepted.
    task automatic send_poll(logic [LEVELS_W-1:0] levels, logic [TIME_W-1:0] now,
                             logic [POS_W-1:0] x, logic [POS_W-1:0] y);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, y, x, now, levels};
        do @(posedge aclk); while (!s_tready);
        pending_reports.push_back(predict_report(levels, now, x, y));
    endtask

    // Stop sending and wait until every expected result has come back.
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_reports.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_window(logic [WINDOW_W-1:0] win);
        wait_drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= win;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        click_window = win;
    endtask

    // Next cursor coordinate: mostly small moves, sometimes jumps and extremes.
    function automatic logic [POS_W-1:0] next_coord(logic [POS_W-1:0] cur);
        case ($urandom_range(0, 9))
            0:       return POS_W'($urandom);
            1:       return 16'h8000;
            2:       return 16'h7FFF;
            default: return cur + POS_W'($urandom_range(0, 64)) - 16'd32;
        endcase
    endfunction

    // Advance the poll clock, mostly by steps that are small next to the window.
    task automatic advance_clock();
        int unsigned win;
        win = click_window;
        case ($urandom_range(0, 19))
            0:       poll_ms = $urandom;
            1:       poll_ms = poll_ms;
            2, 3, 4: poll_ms = poll_ms + $urandom_range(0, 2 * win + 4);
            default: poll_ms = poll_ms + $urandom_range(0, win / 3 + 1);
        endcase
    endtask

    task automatic send_random_poll();
        int b;
        if ($urandom_range(0, 9) == 0) begin
            gen_levels = LEVELS_W'($urandom);
        end else begin
            for (b = 0; b < LEVELS_W; b++) begin
                if ($urandom_range(0, 99) < 35) begin
                    gen_levels[b] = ~gen_levels[b];
                end
            end
        end
        advance_clock();
        gen_x = next_coord(gen_x);
        gen_y = next_coord(gen_y);
        send_poll(gen_levels, poll_ms, gen_x, gen_y);
    endtask

    // Press, release, press, release on one button, quick enough to pair often.
    task automatic send_click_pair();
        int b;
        int k;
        b = $urandom_range(0, LEVELS_W - 1);
        for (k = 0; k < 4; k++) begin
            gen_levels[b] = (k % 2 == 0);
            poll_ms = poll_ms + $urandom_range(0, click_window / 4 + 1);
            gen_x = next_coord(gen_x);
            gen_y = next_coord(gen_y);
            send_poll(gen_levels, poll_ms, gen_x, gen_y);
        end
    endtask

    // Mostly click pairs and level toggles with random timing, plus some noise.
    task automatic test_window(logic [WINDOW_W-1:0] win, int count);
        int sent;
        write_window(win);
        poll_ms = $urandom;
        sent    = 0;
        while (sent < count) begin
            if ($urandom_range(0, 7) == 0) begin
                send_click_pair();
                sent += 4;
            end else begin
                send_random_poll();
                sent++;
            end
        end
    endtask

    // Edges, held levels, double clicks, window boundaries, clock wrap and cursor extremes.
    task automatic test_directed();
        send_poll(3'b000, 32'd0, 16'h0000, 16'h0000);
        send_poll(3'b001, 32'd10, 16'h8000, 16'h7FFF);
        send_poll(3'b001, 32'd20, 16'h7FFF, 16'h8000);
        send_poll(3'b000, 32'd30, 16'h0000, 16'h0000);
        send_poll(3'b001, 32'd40, 16'hFFFF, 16'h0001);
        send_poll(3'b000, 32'd50, 16'h0001, 16'hFFFF);
        // Right click released after the window has passed: plain up.
        send_poll(3'b010, 32'd100, 16'h0010, 16'h0020);
        send_poll(3'b000, 32'd700, 16'h0011, 16'h0021);
        // Middle: a stale first click restarts, then a double click right at the window.
        send_poll(3'b100, 32'd1000, 16'h0012, 16'h0022);
        send_poll(3'b000, 32'd1010, 16'h0013, 16'h0023);
        send_poll(3'b100, 32'd1600, 16'h0014, 16'h0024);
        send_poll(3'b000, 32'd1700, 16'h0015, 16'h0025);
        send_poll(3'b100, 32'd1800, 16'h0016, 16'h0026);
        send_poll(3'b000, 32'd2100, 16'h0017, 16'h0027);
        // All buttons across the clock wrap; second release one past the window.
        send_poll(3'b111, 32'hFFFF_FF00, 16'h7FFF, 16'h7FFF);
        send_poll(3'b000, 32'hFFFF_FF80, 16'h8000, 16'h8000);
        send_poll(3'b111, 32'h0000_0010, 16'h7FFF, 16'h7FFF);
        send_poll(3'b000, 32'h0000_00F5, 16'h8000, 16'h8000);
        // Double click with no time passing at all.
        send_poll(3'b111, 32'hFFFF_FFFF, 16'h5555, 16'hAAAA);
        send_poll(3'b000, 32'hFFFF_FFFF, 16'hAAAA, 16'h5555);
        send_poll(3'b111, 32'hFFFF_FFFF, 16'h5555, 16'hAAAA);
        send_poll(3'b111, 32'hFFFF_FFFF, 16'h5555, 16'hAAAA);
        send_poll(3'b000, 32'hFFFF_FFFF, 16'h0000, 16'h0000);
        // First click released exactly at the window is cleared.
        send_poll(3'b001, 32'd5000, 16'h0000, 16'h0000);
        send_poll(3'b000, 32'd5500, 16'h0000, 16'h0000);
        send_poll(3'b001, 32'd5600, 16'h0000, 16'h0000);
    endtask

    // Receiver holds off long enough for the detector to stall its input.
    task automatic test_backpressure();
        int k;
        write_window(16'd800);
        hold_left = 300;
        for (k = 0; k < 60; k++) begin
            send_random_poll();
        end
        wait_drain();
    endtask

    initial begin
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        mismatch_count = 0;
        hold_left      = 0;
        send_idle_pct  = 26;
        recv_idle_pct  = 54;
        for (int b = 0; b < NUM_EV_OUT; b++) begin
            prev_level[b] = 1'b0;
            clicks[b]     = 2'd0;
            press_ms[b]   = '0;
        end
        last_x       = '0;
        last_y       = '0;
        click_window = WINDOW_RESET;
        gen_levels   = '0;
        gen_x        = '0;
        gen_y        = '0;
        poll_ms      = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_window(16'd0, 120);
        test_window(16'hFFFF, 120);

        send_idle_pct = 54;
        recv_idle_pct = 26;
        test_window(16'd1, 120);
        test_window(WINDOW_W'($urandom_range(2, 3000)), 150);
        test_backpressure();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_window(16'd250, 200);
        test_window(WINDOW_W'($urandom_range(2, 3000)), 120);

        wait_drain();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hdl
hdl/bcdd_pkg.sv
hdl/button_click_double_click_detector.sv
hdl/bcdd_checker.sv
tb/tb.sv
